// ===== src/tlnf_pkg.sv =====
// Shared types, constants and helper functions for the traffic light with night flash.
package tlnf_pkg;

   localparam int TIMER_BITS = 16;
   localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

   typedef logic [TIMER_BITS-1:0] timer_type;
   typedef logic [15:0] dur_type;
   typedef logic [16:0] wait_type;

   localparam logic [2:0] REG_GREEN_TIME     = 3'd0;
   localparam logic [2:0] REG_YELLOW_TIME    = 3'd1;
   localparam logic [2:0] REG_RED_TIME       = 3'd2;
   localparam logic [2:0] REG_NIGHT_ON_TIME  = 3'd3;
   localparam logic [2:0] REG_NIGHT_OFF_TIME = 3'd4;
   localparam logic [2:0] REG_POLL_INTERVAL  = 3'd5;
   localparam logic [2:0] REG_DEBOUNCE_TIME  = 3'd6;

   localparam dur_type GREEN_TIME_RST     = 16'd5000;
   localparam dur_type YELLOW_TIME_RST    = 16'd2000;
   localparam dur_type RED_TIME_RST       = 16'd5000;
   localparam dur_type NIGHT_ON_TIME_RST  = 16'd500;
   localparam dur_type NIGHT_OFF_TIME_RST = 16'd1500;
   localparam dur_type POLL_INTERVAL_RST  = 16'd50;
   localparam dur_type DEBOUNCE_TIME_RST  = 16'd300;

   localparam logic [1:0] PHASE_GREEN  = 2'd0;
   localparam logic [1:0] PHASE_YELLOW = 2'd1;
   localparam logic [1:0] PHASE_RED    = 2'd2;

   localparam logic [1:0] PAT_GREEN  = 2'd0;
   localparam logic [1:0] PAT_YELLOW = 2'd1;
   localparam logic [1:0] PAT_RED    = 2'd2;
   localparam logic [1:0] PAT_NIGHT  = 2'd3;

   typedef enum logic [2:0] {
      STEP_IDLE,
      STEP_GREEN,
      STEP_YELLOW,
      STEP_RED,
      STEP_NIGHT_ON,
      STEP_NIGHT_OFF
   } step_type;

   // Timer load for a wait in ticks: zero acts as one, saturate at the timer range.
   function automatic timer_type load_for(input wait_type ticks);
      wait_type t;
      t = (ticks == '0) ? 17'd1 : ticks;
      t = t - 17'd1;
      if ({16'd0, t} > TIMER_MAX) begin
         return TIMER_MAX[TIMER_BITS-1:0];
      end
      return timer_type'(t);
   endfunction

   function automatic logic [2:0] beep_count(input logic [1:0] pat);
      unique case (pat)
         PAT_YELLOW: return 3'd7;
         default:    return 3'd2;
      endcase
   endfunction

   function automatic dur_type beep_len(input logic [1:0] pat, input logic [2:0] seg);
      dur_type len;
      len = '0;
      unique case (pat)
         PAT_GREEN: begin
            if (seg == 3'd0) len = 16'd200;
            else if (seg == 3'd1) len = 16'd800;
         end
         PAT_YELLOW: begin
            if (seg == 3'd6) len = 16'd500;
            else len = 16'd100;
         end
         PAT_RED: begin
            if (seg == 3'd0) len = 16'd500;
            else if (seg == 3'd1) len = 16'd1500;
         end
         default: begin
            if (seg == 3'd0) len = 16'd200;
            else if (seg == 3'd1) len = 16'd1800;
         end
      endcase
      return len;
   endfunction

endpackage

// ===== src/traffic_light_with_night_flash.sv =====
// Traffic light controller with night flash mode, button poller and buzzer sequencer.
//
// Each accepted req_ word is one millisecond tick carrying the active-low button
// level; it yields exactly one rsp_ word with the lamp, buzzer, phase and mode
// after that tick. The poller, light sequencer and buzzer sequencer all advance
// in the cycle a word is accepted; the result is registered with the new state.
// One word is taken every clock cycle, also while a result is held, as long as
// rsp_tready drains the output register. Durations are set through the csr_
// write port; the user must write them only while the stream is idle (unchecked).
module traffic_light_with_night_flash (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [0] button_level, [7:1] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] green_led, [1] red_led, [2] buzzer_on,
                                   // [4:3] light_phase, [5] night_active, [7:6] zero
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [15:0] csr_wdata
);

   tlnf_pkg::dur_type green_time_ff, yellow_time_ff, red_time_ff;
   tlnf_pkg::dur_type night_on_time_ff, night_off_time_ff;
   tlnf_pkg::dur_type poll_interval_ff, debounce_time_ff;

   logic                  night_mode_ff, night_mode_in;
   logic [1:0]            signal_phase_ff, signal_phase_in;
   tlnf_pkg::timer_type   signal_timer_ff, signal_timer_in;
   tlnf_pkg::step_type    light_step_ff, light_step_in;
   logic [2:0]            beep_segment_ff, beep_segment_in;
   tlnf_pkg::timer_type   beep_timer_ff, beep_timer_in;
   logic [1:0]            beep_pattern_ff, beep_pattern_in;
   logic                  beep_lit_ff, beep_lit_in;
   tlnf_pkg::timer_type   poll_timer_ff, poll_timer_in;
   logic                  previous_level_ff, previous_level_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]            rsp_tdata_ff, rsp_tdata_in;

   logic                  accept;
   logic                  level;
   tlnf_pkg::wait_type    poll_wait;
   tlnf_pkg::dur_type     light_len;
   logic [2:0]            seg;
   logic [2:0]            seg_next;
   logic [2:0]            count;
   logic                  green, red;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign level      = req_tdata[0];
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         green_time_ff     <= tlnf_pkg::GREEN_TIME_RST;
         yellow_time_ff    <= tlnf_pkg::YELLOW_TIME_RST;
         red_time_ff       <= tlnf_pkg::RED_TIME_RST;
         night_on_time_ff  <= tlnf_pkg::NIGHT_ON_TIME_RST;
         night_off_time_ff <= tlnf_pkg::NIGHT_OFF_TIME_RST;
         poll_interval_ff  <= tlnf_pkg::POLL_INTERVAL_RST;
         debounce_time_ff  <= tlnf_pkg::DEBOUNCE_TIME_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tlnf_pkg::REG_GREEN_TIME:     green_time_ff     <= csr_wdata;
            tlnf_pkg::REG_YELLOW_TIME:    yellow_time_ff    <= csr_wdata;
            tlnf_pkg::REG_RED_TIME:       red_time_ff       <= csr_wdata;
            tlnf_pkg::REG_NIGHT_ON_TIME:  night_on_time_ff  <= csr_wdata;
            tlnf_pkg::REG_NIGHT_OFF_TIME: night_off_time_ff <= csr_wdata;
            tlnf_pkg::REG_POLL_INTERVAL:  poll_interval_ff  <= csr_wdata;
            tlnf_pkg::REG_DEBOUNCE_TIME:  debounce_time_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         night_mode_ff     <= 1'b0;
         signal_phase_ff   <= tlnf_pkg::PHASE_GREEN;
         signal_timer_ff   <= '0;
         light_step_ff     <= tlnf_pkg::STEP_IDLE;
         beep_segment_ff   <= '0;
         beep_timer_ff     <= '0;
         beep_pattern_ff   <= tlnf_pkg::PAT_GREEN;
         beep_lit_ff       <= 1'b0;
         poll_timer_ff     <= '0;
         previous_level_ff <= 1'b1;
         rsp_tvalid_ff     <= 1'b0;
      end else begin
         night_mode_ff     <= night_mode_in;
         signal_phase_ff   <= signal_phase_in;
         signal_timer_ff   <= signal_timer_in;
         light_step_ff     <= light_step_in;
         beep_segment_ff   <= beep_segment_in;
         beep_timer_ff     <= beep_timer_in;
         beep_pattern_ff   <= beep_pattern_in;
         beep_lit_ff       <= beep_lit_in;
         poll_timer_ff     <= poll_timer_in;
         previous_level_ff <= previous_level_in;
         rsp_tvalid_ff     <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_comb begin
      night_mode_in     = night_mode_ff;
      signal_phase_in   = signal_phase_ff;
      signal_timer_in   = signal_timer_ff;
      light_step_in     = light_step_ff;
      beep_segment_in   = beep_segment_ff;
      beep_timer_in     = beep_timer_ff;
      beep_pattern_in   = beep_pattern_ff;
      beep_lit_in       = beep_lit_ff;
      poll_timer_in     = poll_timer_ff;
      previous_level_in = previous_level_ff;
      poll_wait         = '0;
      light_len         = '0;
      seg               = '0;
      seg_next          = '0;
      count             = '0;

      // button poller
      if (poll_timer_ff != '0) begin
         poll_timer_in = poll_timer_ff - tlnf_pkg::timer_type'(1);
      end else begin
         poll_wait = (poll_interval_ff == '0) ? 17'd1 : {1'b0, poll_interval_ff};
         if (!level && previous_level_ff) begin
            night_mode_in = !night_mode_ff;
            poll_wait     = poll_wait + {1'b0, debounce_time_ff};
         end
         previous_level_in = level;
         poll_timer_in     = tlnf_pkg::load_for(poll_wait);
      end

      // light sequencer
      if (signal_timer_ff != '0) begin
         signal_timer_in = signal_timer_ff - tlnf_pkg::timer_type'(1);
      end else begin
         unique case (light_step_ff)
            tlnf_pkg::STEP_GREEN:    light_step_in = tlnf_pkg::STEP_YELLOW;
            tlnf_pkg::STEP_YELLOW:   light_step_in = tlnf_pkg::STEP_RED;
            tlnf_pkg::STEP_NIGHT_ON: light_step_in = tlnf_pkg::STEP_NIGHT_OFF;
            default: light_step_in = night_mode_in ? tlnf_pkg::STEP_NIGHT_ON
                                                   : tlnf_pkg::STEP_GREEN;
         endcase
         unique case (light_step_in)
            tlnf_pkg::STEP_GREEN: begin
               signal_phase_in = tlnf_pkg::PHASE_GREEN;
               light_len       = green_time_ff;
            end
            tlnf_pkg::STEP_YELLOW: begin
               signal_phase_in = tlnf_pkg::PHASE_YELLOW;
               light_len       = yellow_time_ff;
            end
            tlnf_pkg::STEP_RED: begin
               signal_phase_in = tlnf_pkg::PHASE_RED;
               light_len       = red_time_ff;
            end
            tlnf_pkg::STEP_NIGHT_ON: begin
               signal_phase_in = tlnf_pkg::PHASE_YELLOW;
               light_len       = night_on_time_ff;
            end
            default: begin
               signal_phase_in = tlnf_pkg::PHASE_YELLOW;
               light_len       = night_off_time_ff;
            end
         endcase
         signal_timer_in = tlnf_pkg::load_for({1'b0, light_len});
      end

      // buzzer sequencer
      if (beep_timer_ff != '0) begin
         beep_timer_in = beep_timer_ff - tlnf_pkg::timer_type'(1);
      end else begin
         if (beep_segment_ff == '0) begin
            if (night_mode_in) beep_pattern_in = tlnf_pkg::PAT_NIGHT;
            else if (signal_phase_in > tlnf_pkg::PHASE_RED) beep_pattern_in = tlnf_pkg::PAT_RED;
            else beep_pattern_in = signal_phase_in;
         end
         count         = tlnf_pkg::beep_count(beep_pattern_in);
         seg           = (beep_segment_ff >= count) ? 3'd0 : beep_segment_ff;
         beep_lit_in   = !seg[0] && (seg < 3'd6);
         beep_timer_in = tlnf_pkg::load_for({1'b0, tlnf_pkg::beep_len(beep_pattern_in, seg)});
         seg_next      = seg + 3'd1;
         beep_segment_in = (seg_next >= count) ? 3'd0 : seg_next;
      end

      // hold everything unless a word is taken
      if (!accept) begin
         night_mode_in     = night_mode_ff;
         signal_phase_in   = signal_phase_ff;
         signal_timer_in   = signal_timer_ff;
         light_step_in     = light_step_ff;
         beep_segment_in   = beep_segment_ff;
         beep_timer_in     = beep_timer_ff;
         beep_pattern_in   = beep_pattern_ff;
         beep_lit_in       = beep_lit_ff;
         poll_timer_in     = poll_timer_ff;
         previous_level_in = previous_level_ff;
      end
   end

   always_comb begin
      green = (light_step_in == tlnf_pkg::STEP_GREEN) ||
              (light_step_in == tlnf_pkg::STEP_YELLOW) ||
              (light_step_in == tlnf_pkg::STEP_NIGHT_ON);
      red   = (light_step_in == tlnf_pkg::STEP_RED) ||
              (light_step_in == tlnf_pkg::STEP_YELLOW) ||
              (light_step_in == tlnf_pkg::STEP_NIGHT_ON);
      if (accept) begin
         rsp_tvalid_in = 1'b1;
         rsp_tdata_in  = {2'b00, night_mode_in, signal_phase_in, beep_lit_in, red, green};
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
         rsp_tdata_in  = rsp_tdata_ff;
      end
   end

endmodule
